// ===== rtl/dsbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbf_pkg: shared types and constants of the dual screen brightness fader
// Operation codes, field widths and the stream beat layout.
// ----------------------------------------------------------------------------
package dsbf_pkg;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;

	localparam int LVL_W   = 6;   // signed brightness level
	localparam int MASK_W  = 6;   // blend plane mask
	localparam int CNT_W   = 16;  // step count field
	localparam int QUO_W   = 6;   // quotient and remainder of the level distance
	localparam int IN_W    = 40;  // slave tdata width
	localparam int OUT_W   = 32;  // master tdata width

	typedef logic signed [LVL_W-1:0] level_t;
	typedef logic [MASK_W-1:0]       mask_t;
	typedef logic [QUO_W-1:0]        quo_t;

endpackage

// ===== rtl/dsbf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbf_div: restoring divider for the ramp setup
// Divides a 6-bit level distance by the step count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dsbf_div #(
	parameter int DW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dsbf_pkg::quo_t     dividend,
	input  logic [DW-1:0]      divisor,
	output logic               done,
	output dsbf_pkg::quo_t     quo,
	output dsbf_pkg::quo_t     rem
);
	import dsbf_pkg::*;

	localparam int CW = (DW > QUO_W + 1) ? DW : QUO_W + 1;

	logic              active_q;
	logic [2:0]        cnt_q;
	logic [DW-1:0]     dvs_q;
	quo_t              quo_q;
	logic [QUO_W:0]    rem_q;
	logic [QUO_W:0]    trial;
	logic [CW-1:0]     trial_ext;
	logic [CW-1:0]     diff_ext;
	logic              fits;

	always_comb begin
		trial     = {rem_q[QUO_W-1:0], quo_q[QUO_W-1]};
		trial_ext = CW'(trial);
		fits      = trial_ext >= CW'(dvs_q);
		diff_ext  = trial_ext - CW'(dvs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= 3'(QUO_W - 1);
			end else if (active_q) begin
				// advance one quotient bit; finish after the last one
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					active_q <= 1'b0;
					done     <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (active_q) begin
			if (fits) begin
				rem_q <= diff_ext[QUO_W:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q[QUO_W-1:0];

endmodule

// ===== rtl/dual_screen_brightness_fader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_screen_brightness_fader: linear brightness ramps for two screens
// Start, tick and set items drive one ramp per screen; one result beat each.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the slave stream (s_tvalid/s_tready/s_tdata/s_tuser), the
//   operation in s_tuser. Every accepted item yields exactly one result beat
//   on the master stream (m_tvalid/m_tready/m_tdata) with the write flags,
//   levels and plane masks of both screens plus their busy flags.
//   A tick item advances every running ramp by one frame, a start item with a
//   nonzero step count sets up a ramp on the selected screens and reports the
//   start level, a set item writes a level at once on the selected screens and cancels their ramps.
//   Steps: the item is accepted, then each screen in turn goes through the
//   shared per-screen update unit, then the output register is loaded. A
//   start with nonzero step count first waits for the divider, which
//   retires one quotient bit of the 6-bit level distance per cycle.
//   s_tready is high only while idle.
//   A stalled receiver holds the result in the output register; the next
//   item may still be accepted, and its result waits in the working
//   registers until the output register frees up.
//   Reset stops both ramps and empties the output register.
// ----------------------------------------------------------------------------
module dual_screen_brightness_fader #(
	parameter int SCREENS    = 2,
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [15:0] step_count, [21:16] target_level, [27:22] start_level,
	// [33:28] surface_mask, [35:34] screen_select, [39:36] zero
	input  logic [dsbf_pkg::IN_W-1:0]   s_tdata,
	// [1:0] operation
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] main_write, [6:1] main_level, [12:7] main_surfaces, [13] sub_write,
	// [19:14] sub_level, [25:20] sub_surfaces, [26] main_busy, [27] sub_busy,
	// [31:28] zero
	output logic [dsbf_pkg::OUT_W-1:0]  m_tdata
);
	import dsbf_pkg::*;

	// only the main and sub screens are ever driven
	localparam int NSCR   = (SCREENS < 2) ? SCREENS : 2;
	localparam int LAST   = NSCR - 1;
	localparam int LEN_W  = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
	localparam int SUM_W  = LEN_W + 1;
	localparam logic [0:0] LAST_SCR = 1'(LAST);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SCR  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// input beat fields
	logic [1:0]        op_in;
	logic [LEN_W-1:0]  len_in;
	level_t            tgt_in;
	level_t            from_in;
	mask_t             mask_in;
	logic [1:0]        sel_in;
	logic              accept;
	logic signed [LVL_W:0] dist_in;
	logic              down_in;
	quo_t              mag_in;

	// sequencer and captured item
	logic [1:0]        state_q;
	logic [0:0]        scr_q;
	logic [1:0]        op_q;
	logic [LEN_W-1:0]  len_q;
	level_t            tgt_q;
	level_t            from_q;
	mask_t             mask_q;
	logic [1:0]        sel_q;
	logic              down_q;

	// per-screen ramp state
	level_t            lvl_q   [NSCR];
	level_t            rtgt_q  [NSCR];
	logic              rdown_q [NSCR];
	quo_t              whole_q [NSCR];
	quo_t              frac_q  [NSCR];
	logic [SUM_W-1:0]  sum_q   [NSCR];
	logic [LEN_W-1:0]  rlen_q  [NSCR];
	mask_t             planes_q[NSCR];
	logic              running_q[NSCR];

	// result being assembled
	logic              wr_q [2];
	level_t            lv_q [2];
	mask_t             pl_q [2];

	// divider
	logic              div_start;
	logic              div_done;
	quo_t              div_quo;
	quo_t              div_rem;

	// shared per-screen update unit
	logic              chosen;
	logic signed [8:0] cur9;
	logic signed [8:0] tgt9;
	logic signed [8:0] whole9;
	logic signed [8:0] next9;
	logic signed [8:0] bump9;
	logic signed [8:0] new9;
	logic [SUM_W-1:0]  sumn;
	logic [SUM_W-1:0]  sum_new;
	logic              tick_done;
	logic              out_free;
	logic              busy_main;
	logic              busy_sub;

	assign op_in   = s_tuser;
	assign len_in  = s_tdata[LEN_W-1:0];
	assign tgt_in  = s_tdata[21:16];
	assign from_in = s_tdata[27:22];
	assign mask_in = s_tdata[33:28];
	assign sel_in  = s_tdata[35:34];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// level distance: down when start lies above target, magnitude below 64
	assign dist_in = (LVL_W+1)'(from_in) - (LVL_W+1)'(tgt_in);
	assign down_in = dist_in > 0;
	assign mag_in  = down_in ? dist_in[QUO_W-1:0] : QUO_W'(-dist_in);

	assign div_start = accept && (op_in == OP_START) && (len_in != '0);

	dsbf_div #(
		.DW(LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_in),
		.divisor  (len_in),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// one frame of the ramp on the screen under scr_q
	always_comb begin
		chosen  = sel_q[scr_q];
		cur9    = 9'(lvl_q[scr_q]);
		tgt9    = 9'(rtgt_q[scr_q]);
		whole9  = $signed({3'b000, whole_q[scr_q]});
		next9   = rdown_q[scr_q] ? cur9 - whole9 : cur9 + whole9;
		bump9   = rdown_q[scr_q] ? next9 - 9'sd1 : next9 + 9'sd1;
		sumn    = sum_q[scr_q] + SUM_W'(frac_q[scr_q]);
		new9    = next9;
		sum_new = sumn;
		tick_done = 1'b0;
		if ((next9 != tgt9) && (cur9 != tgt9)) begin
			if (sumn >= SUM_W'(rlen_q[scr_q])) begin
				// carry the extra unit; stop if it lands on the target
				new9 = bump9;
				if (bump9 != tgt9) begin
					sum_new = sumn - SUM_W'(rlen_q[scr_q]);
				end else begin
					tick_done = 1'b1;
				end
			end
		end else begin
			// snap to the target
			new9      = tgt9;
			tick_done = 1'b1;
		end
	end

	assign out_free  = !m_tvalid || m_tready;
	assign busy_main = running_q[0];
	assign busy_sub  = (NSCR > 1) ? running_q[LAST] : 1'b0;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scr_q    <= '0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < NSCR; i++) begin
				running_q[i] <= 1'b0;
			end
		end else begin
			// drop valid once the beat is taken; ST_OUT drives valid itself
			if (m_tvalid && m_tready && (state_q != ST_OUT)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scr_q   <= '0;
						state_q <= div_start ? ST_DIV : ST_SCR;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SCR;
					end
				end
				ST_SCR: begin
					case (op_q)
						OP_TICK: begin
							if (running_q[scr_q] && tick_done) begin
								running_q[scr_q] <= 1'b0;
							end
						end
						OP_START: begin
							if (chosen && (len_q != '0)) begin
								running_q[scr_q] <= 1'b1;
							end
						end
						OP_SET: begin
							if (chosen) begin
								running_q[scr_q] <= 1'b0;
							end
						end
						default: begin
						end
					endcase
					if (scr_q == LAST_SCR) begin
						state_q <= ST_OUT;
					end else begin
						scr_q <= scr_q + 1'b1;
					end
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// captured item, ramp payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_in;
			len_q  <= len_in;
			tgt_q  <= tgt_in;
			from_q <= from_in;
			mask_q <= mask_in;
			sel_q  <= sel_in;
			down_q <= down_in;
			for (int i = 0; i < 2; i++) begin
				wr_q[i] <= 1'b0;
				lv_q[i] <= '0;
				pl_q[i] <= '0;
			end
		end
		if (state_q == ST_SCR) begin
			case (op_q)
				OP_TICK: begin
					if (running_q[scr_q]) begin
						lvl_q[scr_q] <= new9[LVL_W-1:0];
						if ((next9 != tgt9) && (cur9 != tgt9)) begin
							sum_q[scr_q] <= sum_new;
						end
						wr_q[scr_q] <= 1'b1;
						lv_q[scr_q] <= new9[LVL_W-1:0];
						pl_q[scr_q] <= planes_q[scr_q];
					end
				end
				OP_START: begin
					if (chosen && (len_q != '0)) begin
						lvl_q[scr_q]    <= from_q;
						rtgt_q[scr_q]   <= tgt_q;
						rdown_q[scr_q]  <= down_q;
						whole_q[scr_q]  <= div_quo;
						frac_q[scr_q]   <= div_rem;
						sum_q[scr_q]    <= '0;
						rlen_q[scr_q]   <= len_q;
						planes_q[scr_q] <= mask_q;
						wr_q[scr_q]     <= 1'b1;
						lv_q[scr_q]     <= from_q;
						pl_q[scr_q]     <= mask_q;
					end
				end
				OP_SET: begin
					if (chosen) begin
						wr_q[scr_q] <= 1'b1;
						lv_q[scr_q] <= from_q;
						pl_q[scr_q] <= mask_q;
					end
				end
				default: begin
				end
			endcase
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata <= {4'b0000, busy_sub, busy_main,
			            pl_q[1], lv_q[1], wr_q[1],
			            pl_q[0], lv_q[0], wr_q[0]};
		end
	end

	// the divider only finishes while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside of the divide phase");

	// an accepted item blocks the next one in the following cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item accepted while one is in work");

	// a set item leaves the main ramp stopped when main is selected
	a_set_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && (op_q == OP_SET) && sel_q[0] |-> !running_q[0])
		else $error("set item left the main ramp running");

	// a result is loaded only when the output register can take it
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && m_tvalid && !m_tready |=> (state_q == ST_OUT))
		else $error("result left the sequencer while output was stalled");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual screen brightness fader
// Drives tick, start, set and unused items on the slave stream and predicts
// every result beat from a private copy of both screens' ramp state. Both
// streams idle at random, with quiet stretches at full rate.
// ----------------------------------------------------------------------------
module tb;
	import dsbf_pkg::*;

	// the operation code that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// cycles without any accepted beat before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// items in the random part
	localparam int RANDOM_ITEMS = 2000;

	// one slave beat, split into its fields
	typedef struct {
		logic [1:0] op;
		logic [15:0] frames;
		level_t goal;
		level_t origin;
		mask_t planes;
		logic [1:0] screens;
	} fade_cmd_t;

	// one master beat, laid out as m_tdata from the top bit down
	typedef struct packed {
		logic [3:0] pad;
		logic sub_busy;
		logic main_busy;
		mask_t sub_surfaces;
		level_t sub_level;
		logic sub_write;
		mask_t main_surfaces;
		level_t main_level;
		logic main_write;
	} screen_report_t;

	// Scoreboard: mirrors the ramp state of both screens and keeps the
	// reports owed by the block in arrival order.
	class fade_scoreboard;
		level_t lvl[2];
		level_t goal[2];
		bit down[2];
		logic [5:0] whole[2];
		logic [15:0] frac[2];
		logic [16:0] acc[2];
		logic [15:0] span[2];
		mask_t planes[2];
		bit active[2];
		screen_report_t owed_reports[$];
		int mismatches;

		function new();
			mismatches = 0;
			cancel_ramp(0);
			cancel_ramp(1);
		endfunction

		function void cancel_ramp(int s);
			lvl[s] = '0;
			goal[s] = '0;
			down[s] = 1'b0;
			whole[s] = '0;
			frac[s] = '0;
			acc[s] = '0;
			span[s] = '0;
			planes[s] = '0;
			active[s] = 1'b0;
		endfunction

		function void launch_ramp(int s, fade_cmd_t c);
			int delta;
			int len;
			int q;
			int r;
			delta = int'(c.origin) - int'(c.goal);
			len = c.frames;
			active[s] = 1'b1;
			planes[s] = c.planes;
			span[s] = c.frames;
			goal[s] = c.goal;
			lvl[s] = c.origin;
			if (delta > 0) begin
				down[s] = 1'b1;
			end else begin
				down[s] = 1'b0;
				delta = -delta;
			end
			q = delta / len;
			r = delta % len;
			whole[s] = q[5:0];
			frac[s] = r[15:0];
			acc[s] = '0;
		endfunction

		// one frame of Bresenham stepping; snap to the goal on arrival
		function void advance_ramp(int s);
			int dir;
			int cur;
			int nxt;
			bit done;
			dir = down[s] ? -1 : 1;
			cur = lvl[s];
			nxt = cur + dir * int'(whole[s]);
			done = 1'b0;
			if (nxt != int'(goal[s]) && cur != int'(goal[s])) begin
				cur = nxt;
				acc[s] = acc[s] + {1'b0, frac[s]};
				if (acc[s] >= {1'b0, span[s]}) begin
					cur = cur + dir;
					if (cur != int'(goal[s]))
						acc[s] = acc[s] - {1'b0, span[s]};
					else
						done = 1'b1;
				end
			end else begin
				cur = goal[s];
				done = 1'b1;
			end
			lvl[s] = cur[5:0];
			if (done)
				active[s] = 1'b0;
		endfunction

		// note an accepted slave beat: update the mirror, queue its report
		function void note_item(fade_cmd_t c);
			screen_report_t rep;
			logic wr[2];
			level_t lv[2];
			mask_t pl[2];
			for (int s = 0; s < 2; s++) begin
				wr[s] = 1'b0;
				lv[s] = '0;
				pl[s] = '0;
				case (c.op)
					OP_TICK: begin
						if (active[s]) begin
							advance_ramp(s);
							wr[s] = 1'b1;
							lv[s] = lvl[s];
							pl[s] = planes[s];
						end
					end
					OP_START: begin
						if (c.frames != 0 && c.screens[s]) begin
							wr[s] = 1'b1;
							lv[s] = c.origin;
							pl[s] = c.planes;
							launch_ramp(s, c);
						end
					end
					OP_SET: begin
						if (c.screens[s]) begin
							wr[s] = 1'b1;
							lv[s] = c.origin;
							pl[s] = c.planes;
							cancel_ramp(s);
						end
					end
					default: ;
				endcase
			end
			rep = '0;
			rep.main_write = wr[0];
			rep.main_level = lv[0];
			rep.main_surfaces = pl[0];
			rep.sub_write = wr[1];
			rep.sub_level = lv[1];
			rep.sub_surfaces = pl[1];
			rep.main_busy = active[0];
			rep.sub_busy = active[1];
			owed_reports.push_back(rep);
		endfunction

		function void verify(string field, logic signed [31:0] want,
			logic signed [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", field, want, seen);
				mismatches++;
			end
		endfunction

		// check an accepted master beat against the oldest owed report
		function void check_beat(logic [OUT_W-1:0] beat);
			screen_report_t want;
			screen_report_t seen;
			if (owed_reports.size() == 0) begin
				$error("result beat 0x%08h with no item outstanding", beat);
				mismatches++;
				return;
			end
			want = owed_reports.pop_front();
			seen = beat;
			verify("main_write", want.main_write, seen.main_write);
			verify("main_level", want.main_level, seen.main_level);
			verify("main_surfaces", want.main_surfaces, seen.main_surfaces);
			verify("sub_write", want.sub_write, seen.sub_write);
			verify("sub_level", want.sub_level, seen.sub_level);
			verify("sub_surfaces", want.sub_surfaces, seen.sub_surfaces);
			verify("main_busy", want.main_busy, seen.main_busy);
			verify("sub_busy", want.sub_busy, seen.sub_busy);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// [15:0] step_count, [21:16] target_level, [27:22] start_level,
	// [33:28] surface_mask, [35:34] screen_select, [39:36] zero
	logic [IN_W-1:0] s_tdata;
	// [1:0] operation
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// [0] main_write, [6:1] main_level, [12:7] main_surfaces, [13] sub_write,
	// [19:14] sub_level, [25:20] sub_surfaces, [26] main_busy, [27] sub_busy,
	// [31:28] zero
	logic [OUT_W-1:0] m_tdata;

	fade_scoreboard sb;
	int idle_cycles;
	int sender_quiet;
	int receiver_quiet;
	int items_sent;

	dual_screen_brightness_fader dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Hang detection: count cycles in which neither stream moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Draw the wait before the next beat: mostly a random gap, now and then
	// a stretch of back-to-back beats.
	function automatic int pick_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 12);
	endfunction

	function automatic level_t any_level();
		return level_t'($urandom_range(0, 32) - 16);
	endfunction

	function automatic fade_cmd_t make_cmd(logic [1:0] op, logic [15:0] frames,
		int goal, int origin, logic [5:0] planes, logic [1:0] screens);
		fade_cmd_t c;
		c.op = op;
		c.frames = frames;
		c.goal = level_t'(goal);
		c.origin = level_t'(origin);
		c.planes = planes;
		c.screens = screens;
		return c;
	endfunction

	// a beat whose unused fields carry random content
	function automatic fade_cmd_t random_cmd(logic [1:0] op);
		return make_cmd(op, 16'($urandom), any_level(), any_level(),
			6'($urandom), 2'($urandom));
	endfunction

	// Present one item on the slave stream and hold it until accepted.
	// Called right after an acceptance edge (or after reset), so the first
	// falling edge below belongs to this item.
	task automatic issue_command(fade_cmd_t c);
		int gap;
		gap = pick_wait(sender_quiet);
		@(negedge clk);
		if (gap != 0) begin
			// drop valid for the gap; raise it again only at a later edge
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {4'b0, c.screens, c.planes, c.origin, c.goal, c.frames};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(c);
		items_sent++;
	endtask

	// Drain the master stream forever, stalling at random before each beat.
	task automatic collect_reports();
		int stall;
		forever begin
			stall = pick_wait(receiver_quiet);
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			sb.check_beat(m_tdata);
		end
	endtask

	// A well-formed fade: start a ramp on some screens, then tick it through
	// to the end, with a stray set or restart dropped in now and then.
	task automatic run_fade();
		fade_cmd_t c;
		int ticks;
		c = make_cmd(OP_START, 16'($urandom_range(1, 24)), any_level(),
			any_level(), 6'($urandom), 2'($urandom_range(1, 3)));
		if ($urandom_range(0, 15) == 0)
			c.frames = 16'($urandom_range(25, 65535));
		issue_command(c);
		ticks = (c.frames > 30 ? 30 : int'(c.frames)) + $urandom_range(0, 2);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 24) == 0)
				issue_command(random_cmd($urandom_range(0, 1) ? OP_SET : OP_START));
			else
				issue_command(random_cmd(OP_TICK));
		end
	endtask

	initial begin
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		m_tready = 1'b0;
		idle_cycles = 0;
		sender_quiet = 0;
		receiver_quiet = 0;
		items_sent = 0;
		sb = new();

		// hold reset, then release it away from the active edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			collect_reports();
		join_none

		// Directed part.
		// tick with no ramp running, then sets at levels 16 and -16
		issue_command(make_cmd(OP_TICK, 16'h0000, 0, 0, 6'h00, 2'd3));
		issue_command(make_cmd(OP_SET, 16'hffff, -16, 16, 6'h3f, 2'd3));
		issue_command(make_cmd(OP_SET, 16'h0000, 16, -16, 6'h00, 2'd1));
		// zero step count: start must leave both screens alone
		issue_command(make_cmd(OP_START, 16'h0000, 16, -16, 6'h3f, 2'd3));
		// climb from -16 to 16 on main with an even whole step, ticked to arrival
		issue_command(make_cmd(OP_START, 16'd4, 16, -16, 6'h2a, 2'd1));
		repeat (4) issue_command(make_cmd(OP_TICK, 16'h0000, 0, 0, 6'h00, 2'd0));
		// longest ramp on sub: whole step zero, remainder only
		issue_command(make_cmd(OP_START, 16'hffff, -16, 16, 6'h15, 2'd2));
		// restart both screens while sub is busy
		issue_command(make_cmd(OP_START, 16'd3, -7, 5, 6'h3f, 2'd3));
		// restart main again with a remainder that needs extra units
		issue_command(make_cmd(OP_START, 16'd7, 10, -3, 6'h01, 2'd1));
		// unused operation code must change nothing
		issue_command(make_cmd(OP_UNUSED, 16'hffff, 16, 16, 6'h3f, 2'd3));
		repeat (7) issue_command(make_cmd(OP_TICK, 16'h0000, 0, 0, 6'h00, 2'd3));
		// set on sub after its ramp has already ended
		issue_command(make_cmd(OP_SET, 16'h0000, 0, 0, 6'h30, 2'd2));
		// ramp whose start equals its goal: arrives on the first tick
		issue_command(make_cmd(OP_START, 16'd1, 4, 4, 6'h0c, 2'd3));
		issue_command(make_cmd(OP_TICK, 16'h0000, 0, 0, 6'h00, 2'd0));
		// one-frame jump from zero to level 16
		issue_command(make_cmd(OP_START, 16'd1, 16, 0, 6'h3f, 2'd1));
		issue_command(make_cmd(OP_TICK, 16'hffff, -16, -16, 6'h3f, 2'd3));

		// Random part: mostly complete fades, the rest noise.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				run_fade();
			end else if (pick < 75) begin
				issue_command(random_cmd(OP_SET));
			end else if (pick < 85) begin
				// start with random count; zero now and then
				issue_command(random_cmd(OP_START));
			end else if (pick < 90) begin
				issue_command(make_cmd(OP_START, 16'h0000, any_level(), any_level(),
					6'($urandom), 2'($urandom)));
			end else if (pick < 97) begin
				repeat ($urandom_range(1, 5)) issue_command(random_cmd(OP_TICK));
			end else begin
				issue_command(random_cmd(OP_UNUSED));
			end
		end

		// drop valid after the last beat, then wait for the owed reports
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.owed_reports.size() != 0)
			@(posedge clk);
		// give a stray extra beat the chance to show up
		repeat (24) @(posedge clk);

		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dsbf_pkg.sv
rtl/dsbf_div.sv
rtl/dual_screen_brightness_fader.sv
tb/sv/tb.sv
